### rtl/mctg_pkg.sv
// ============================================================================
// mctg_pkg
// Shared types, constants and tables of the multichannel chirp tone generator.
// ============================================================================
`default_nettype none

package mctg_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_N_CHANNELS    = 8;
    localparam int DEF_PHASE_BITS    = 32;
    localparam int DEF_CORDIC_STAGES = 16;

    // The arctangent table holds this many entries.
    localparam int ATAN_ENTRIES = 24;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_MODE         = 3'd0;
    localparam logic [2:0] CFG_PERIOD       = 3'd1;
    localparam logic [2:0] CFG_PULSE_START  = 3'd2;
    localparam logic [2:0] CFG_PULSE_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_FREQ_WORD    = 3'd4;
    localparam logic [2:0] CFG_CHIRP_STEP   = 3'd5;
    localparam logic [2:0] CFG_AMPLITUDE    = 3'd6;
    localparam logic [2:0] CFG_CHAN_WORD    = 3'd7;

    // Waveform codes. Code 3 is unused and behaves as constant phase.
    localparam logic [1:0] MODE_LFM   = 2'd0;
    localparam logic [1:0] MODE_TONE  = 2'd1;
    localparam logic [1:0] MODE_CONST = 2'd2;

    // CORDIC gain compensation, 2^30 / 1.6467...
    localparam logic [29:0] K_Q30 = 30'd652032874;

    // Width of the CORDIC datapath words.
    localparam int CW = 32;

    // Information that travels with each item through the CORDIC chain.
    typedef struct packed {
        logic        valid;
        logic        active;
        logic [1:0]  quad;
        logic [15:0] sample;
        logic [5:0]  channel;
        logic        last;
    } t_meta;

    // Arctangent of 2^-i in units of 2^-32 of a full turn.
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/mctg_cell.sv
// ============================================================================
// mctg_cell
// One CORDIC rotation cell: rotates (x, y) by the table angle of its stage
// toward a zero residual angle and hands the result to the next cell.
// ============================================================================
`default_nettype none

module mctg_cell #(
    parameter int STAGE = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire  signed [mctg_pkg::CW-1:0] i_x,
    input  wire  signed [mctg_pkg::CW-1:0] i_y,
    input  wire  signed [mctg_pkg::CW-1:0] i_z,
    input  mctg_pkg::t_meta              i_meta,
    output logic signed [mctg_pkg::CW-1:0] o_x,
    output logic signed [mctg_pkg::CW-1:0] o_y,
    output logic signed [mctg_pkg::CW-1:0] o_z,
    output mctg_pkg::t_meta              o_meta
);
    import mctg_pkg::*;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [CW-1:0] n_z;

    assign dx = i_y >>> STAGE;
    assign dy = i_x >>> STAGE;
    assign at = signed'(atan_turn(STAGE));

    // A zero residual angle counts as positive.
    always_comb begin
        if (!i_z[CW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - at;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_meta.valid <= 1'b0;
        end else if (i_en) begin
            o_meta.valid <= i_meta.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x           <= n_x;
            o_y           <= n_y;
            o_z           <= n_z;
            o_meta.active <= i_meta.active;
            o_meta.quad   <= i_meta.quad;
            o_meta.sample <= i_meta.sample;
            o_meta.channel <= i_meta.channel;
            o_meta.last   <= i_meta.last;
        end
    end

endmodule

`default_nettype wire

### rtl/mctg_post.sv
// ============================================================================
// mctg_post
// Output stage: applies the quadrant, rounds and saturates to 16 bits (zero for an
// inactive item), and holds the finished item in the output register until it is taken.
// ============================================================================
`default_nettype none

module mctg_post (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire  signed [mctg_pkg::CW-1:0] i_x,
    input  wire  signed [mctg_pkg::CW-1:0] i_y,
    input  mctg_pkg::t_meta              i_meta,
    output logic                         o_valid,
    output logic signed [15:0]           o_i_value,
    output logic signed [15:0]           o_q_value,
    output logic [15:0]                  o_sample,
    output logic [5:0]                   o_channel,
    output logic                         o_last
);
    import mctg_pkg::*;

    logic signed [CW-1:0] c_val;
    logic signed [CW-1:0] s_val;
    logic signed [15:0]   n_i;
    logic signed [15:0]   n_q;

    function automatic logic signed [15:0] round_sat(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        logic signed [CW:0] r;
        logic signed [15:0] o;
        t = (CW+1)'(v) + $signed((CW+1)'(32768));
        r = t >>> 16;
        if (r < $signed(-(CW+1)'(32768))) begin
            o = 16'sh8000;
        end else if (r > $signed((CW+1)'(32767))) begin
            o = 16'sh7FFF;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

    always_comb begin
        case (i_meta.quad)
            2'd0: begin
                c_val = i_x;
                s_val = i_y;
            end
            2'd1: begin
                c_val = -i_y;
                s_val = i_x;
            end
            2'd2: begin
                c_val = -i_x;
                s_val = -i_y;
            end
            default: begin
                c_val = i_y;
                s_val = -i_x;
            end
        endcase
        if (i_meta.active) begin
            n_i = round_sat(c_val);
            n_q = round_sat(s_val);
        end else begin
            n_i = 16'sd0;
            n_q = 16'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_meta.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_i_value <= n_i;
            o_q_value <= n_q;
            o_sample  <= i_meta.sample;
            o_channel <= i_meta.channel;
            o_last    <= i_meta.last;
        end
    end

endmodule

`default_nettype wire

### rtl/multichannel_chirp_tone_generator.sv
// ============================================================================
// multichannel_chirp_tone_generator
// Direct digital synthesis of chirp, tone or constant-phase complex samples,
// channel-interleaved, with a chain of CORDIC rotation cells.
// ============================================================================
//
//  channel   direction  payload
//  s_axis    in         tdata[0] restart
//  m_axis    out        tdata i, q, sample index, channel index; tlast end of period
//  cfg       in         we, addr (register index), data (up to 32 bits)
//
// One item is accepted and one leaves every cycle while the output is not held;
// an item passes the front register, the CORDIC cell chain (at most 24 cells)
// and the output register on its way from input to output.
// Reset is synchronous, clears the phase and position state and loads the
// register defaults. While the output item is held, the whole chain holds
// and s_axis tready is low.
`default_nettype none

module multichannel_chirp_tone_generator #(
    parameter int N_CHANNELS    = mctg_pkg::DEF_N_CHANNELS,
    parameter int PHASE_BITS    = mctg_pkg::DEF_PHASE_BITS,
    parameter int CORDIC_STAGES = mctg_pkg::DEF_CORDIC_STAGES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,    // [0] restart
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,    // [15:0] i_value, [31:16] q_value,
                                           // [47:32] sample_index, [53:48] channel_index
    output logic        o_m_axis_tlast,    // end_of_period
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_data
);
    import mctg_pkg::*;

    localparam int PB   = PHASE_BITS;
    localparam int CH_W = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1;
    localparam int NS   = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int SHL  = (PB >= 32) ? PB - 32 : 0;
    localparam int SHR  = (PB < 32) ? 32 - PB : 0;

    // Configuration registers.
    logic [1:0]         r_mode;
    logic [15:0]        r_period;
    logic [15:0]        r_pulse_start;
    logic [15:0]        r_pulse_width;
    logic [31:0]        r_freq_word;
    logic [31:0]        r_chirp_step;
    logic [12:0]        r_amplitude;
    logic [31:0]        r_chan_word;

    // Sequencer state.
    logic [15:0]        r_sample_pos;
    logic [CH_W-1:0]    r_channel_pos;
    logic [PB-1:0]      r_sample_phase;
    logic [PB-1:0]      r_phase_inc;
    logic [PB-1:0]      r_chan_phase;

    logic [15:0]        n_sample_pos;
    logic [CH_W-1:0]    n_channel_pos;
    logic [PB-1:0]      n_sample_phase;
    logic [PB-1:0]      n_phase_inc;
    logic [PB-1:0]      n_chan_phase;

    logic               adv;
    logic               accept;
    logic               restart;

    logic [15:0]        c_s;
    logic [CH_W-1:0]    c_ch;
    logic [PB-1:0]      c_sp;
    logic [PB-1:0]      c_pi;
    logic [PB-1:0]      c_cp;

    logic signed [63:0] fst_ext;
    logic signed [63:0] cst_ext;
    logic signed [63:0] fst_sh;
    logic signed [63:0] cst_sh;
    logic [63:0]        cpw_sh;
    logic [PB-1:0]      fst;
    logic [PB-1:0]      cst;
    logic [PB-1:0]      cpw;
    logic [PB-1:0]      half;
    logic [PB-1:0]      inc;
    logic [PB-1:0]      base;

    logic               in_win;
    logic               k_zero;
    logic               last_s;
    logic               last_ch;
    logic [15:0]        period;
    logic               active;
    logic [PB-1:0]      p_sel;
    logic [PB-1:0]      tot;
    logic [63:0]        tot32_sh;

    // Front register between the sequencer and the CORDIC chain.
    t_meta              r_q_meta;
    logic [31:0]        r_q_ph;
    logic [28:0]        r_x0;
    logic [42:0]        x0_prod;
    logic [31:0]        pz;

    t_meta              w_meta [0:NS];
    logic signed [CW-1:0] w_x  [0:NS];
    logic signed [CW-1:0] w_y  [0:NS];
    logic signed [CW-1:0] w_z  [0:NS];

    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic [15:0]        out_sample;
    logic [5:0]         out_channel;

    assign adv             = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign accept          = i_s_axis_tvalid && adv;
    assign restart         = i_s_axis_tdata[0];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_LFM;
            r_period      <= 16'd4096;
            r_pulse_start <= 16'd100;
            r_pulse_width <= 16'd256;
            r_freq_word   <= 32'hACAA_AAAB;
            r_chirp_step  <= 32'd10922667;
            r_amplitude   <= 13'd8191;
            r_chan_word   <= 32'd341782638;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MODE:        r_mode        <= i_cfg_data[1:0];
                CFG_PERIOD:      r_period      <= i_cfg_data[15:0];
                CFG_PULSE_START: r_pulse_start <= i_cfg_data[15:0];
                CFG_PULSE_WIDTH: r_pulse_width <= i_cfg_data[15:0];
                CFG_FREQ_WORD:   r_freq_word   <= i_cfg_data;
                CFG_CHIRP_STEP:  r_chirp_step  <= i_cfg_data;
                CFG_AMPLITUDE:   r_amplitude   <= i_cfg_data[12:0];
                CFG_CHAN_WORD:   r_chan_word   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Rescale the 32-bit words to the accumulator width.
    assign fst_ext = signed'({{32{r_freq_word[31]}}, r_freq_word});
    assign cst_ext = signed'({{32{r_chirp_step[31]}}, r_chirp_step});
    assign fst_sh  = (fst_ext <<< SHL) >>> SHR;
    assign cst_sh  = (cst_ext <<< SHL) >>> SHR;
    assign cpw_sh  = ({32'd0, r_chan_word} << SHL) >> SHR;
    assign fst     = fst_sh[PB-1:0];
    assign cst     = cst_sh[PB-1:0];
    assign cpw     = cpw_sh[PB-1:0];
    assign half    = {cst[PB-1], cst[PB-1:1]};

    always_comb begin
        if (restart) begin
            c_s  = 16'd0;
            c_ch = '0;
            c_sp = '0;
            c_pi = '0;
            c_cp = '0;
        end else begin
            c_s  = r_sample_pos;
            c_ch = r_channel_pos;
            c_sp = r_sample_phase;
            c_pi = r_phase_inc;
            c_cp = r_chan_phase;
        end

        in_win  = (c_s >= r_pulse_start) && ((c_s - r_pulse_start) < r_pulse_width);
        k_zero  = (c_s == r_pulse_start);
        period  = (r_period == 16'd0) ? 16'd1 : r_period;
        last_s  = ({1'b0, c_s} + 17'd1) >= {1'b0, period};
        last_ch = (c_ch >= CH_W'(N_CHANNELS - 1));

        case (r_mode)
            MODE_LFM: begin
                active = in_win;
                p_sel  = (in_win && !k_zero) ? c_sp : '0;
            end
            MODE_TONE: begin
                active = 1'b1;
                p_sel  = c_sp;
            end
            default: begin
                active = 1'b1;
                p_sel  = '0;
            end
        endcase
        tot      = p_sel + c_cp;
        tot32_sh = ({{(64-PB){1'b0}}, tot} >> SHL) << SHR;

        // The first chirp increment is the start frequency plus half a step.
        base = k_zero ? '0 : c_sp;
        inc  = k_zero ? (fst + half) : c_pi;

        n_sample_pos   = c_s;
        n_channel_pos  = c_ch;
        n_sample_phase = c_sp;
        n_phase_inc    = c_pi;
        n_chan_phase   = c_cp;
        if (!last_ch) begin
            n_channel_pos = c_ch + CH_W'(1);
            n_chan_phase  = c_cp + cpw;
        end else begin
            n_channel_pos = '0;
            n_chan_phase  = '0;
            if (last_s) begin
                n_sample_pos   = 16'd0;
                n_sample_phase = '0;
                n_phase_inc    = '0;
            end else begin
                n_sample_pos = c_s + 16'd1;
                case (r_mode)
                    MODE_LFM: begin
                        if (in_win) begin
                            n_sample_phase = base + inc;
                            n_phase_inc    = inc + cst;
                        end else begin
                            n_sample_phase = '0;
                            n_phase_inc    = '0;
                        end
                    end
                    MODE_TONE: n_sample_phase = c_sp + fst;
                    default:   n_sample_phase = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_pos   <= 16'd0;
            r_channel_pos  <= '0;
            r_sample_phase <= '0;
            r_phase_inc    <= '0;
            r_chan_phase   <= '0;
        end else if (accept) begin
            r_sample_pos   <= n_sample_pos;
            r_channel_pos  <= n_channel_pos;
            r_sample_phase <= n_sample_phase;
            r_phase_inc    <= n_phase_inc;
            r_chan_phase   <= n_chan_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_meta.valid <= 1'b0;
        end else if (adv) begin
            r_q_meta.valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q_meta.active  <= active;
            r_q_meta.quad    <= 2'd0;
            r_q_meta.sample  <= c_s;
            r_q_meta.channel <= 6'(c_ch);
            r_q_meta.last    <= last_ch && last_s;
            r_q_ph           <= tot32_sh[31:0];
        end
    end

    // The starting magnitude follows the amplitude register; the user must make changes
    // to it only while the chain is empty, as the block itself does not enforce this.
    assign x0_prod = 43'(r_amplitude) * 43'(K_Q30) + 43'd8192;

    always_ff @(posedge i_clk) begin
        r_x0 <= x0_prod[42:14];
    end

    // Shift by an eighth of a turn: the top two bits pick the quadrant, the rest less
    // an eighth of a turn is the residual angle.
    assign pz = r_q_ph + 32'h2000_0000;

    always_comb begin
        w_meta[0]      = r_q_meta;
        w_meta[0].quad = pz[31:30];
        w_x[0]         = signed'(CW'(r_x0));
        w_y[0]         = '0;
        w_z[0]         = signed'({2'b00, pz[29:0]}) - signed'(32'h2000_0000);
    end

    for (genvar g = 0; g < NS; g++) begin : g_cell
        mctg_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_meta  (w_meta[g]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_meta  (w_meta[g+1])
        );
    end

    mctg_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_x       (w_x[NS]),
        .i_y       (w_y[NS]),
        .i_meta    (w_meta[NS]),
        .o_valid   (o_m_axis_tvalid),
        .o_i_value (out_i),
        .o_q_value (out_q),
        .o_sample  (out_sample),
        .o_channel (out_channel),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, out_channel, out_sample, out_q, out_i};

endmodule

`default_nettype wire

### test/multichannel_chirp_tone_generator_tb.sv
// ============================================================================
// multichannel_chirp_tone_generator_tb
// Self-checking bench for the chirp, tone and constant-phase sample generator.
// Each accepted item is run through a bit-true model of the phase
// accumulators and the CORDIC rotator kept in this bench. The predicted
// samples are queued and compared field by field with the output stream.
// Both stream sides idle at random, and the receiver holds off once for a
// long stretch so that the generator fills up and stalls its input.
// ============================================================================
`default_nettype none

module multichannel_chirp_tone_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mctg_pkg::*;

    localparam int  NUM_CH       = DEF_N_CHANNELS;
    localparam int  ROT_STAGES   = DEF_CORDIC_STAGES;
    localparam int  PIPE_LATENCY = DEF_CORDIC_STAGES + 1;
    localparam int  LIMIT_CYCLES = 400000;
    localparam int  RX_HOLD_LEN  = 200;
    localparam int  PRINT_LIMIT  = 40;
    localparam longint GAIN_Q30  = 652032874;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] i_val;
        logic [15:0] q_val;
        logic [15:0] sample;
        logic [5:0]  chan;
        logic        eop;
    } t_tone_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;     // [0] restart
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;          // [15:0] i, [31:16] q, [47:32] sample,
                                          // [53:48] channel
    logic        o_m_axis_tlast;          // end of period
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;

    // Register copies and generator state of the predictor.
    logic [31:0] cfg_shadow [0:7];
    logic [15:0] sample_pos;
    logic [5:0]  chan_pos;
    logic [31:0] acc_phase;
    logic [31:0] acc_step;
    logic [31:0] chan_phase;

    longint arctan_turns [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    t_tone_sample pending_samples [$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  restarts_sent = 0;
    int  results_checked = 0;
    int  settings_used = 0;
    int  cycle_count = 0;
    int  input_stall_cycles = 0;
    bit  tx_gaps_on = 1'b0;
    bit  rx_stalls_on = 1'b0;
    bit  rx_hold_req = 1'b0;

    multichannel_chirp_tone_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_s_axis_tvalid && !o_s_axis_tready && i_rst_n)
            input_stall_cycles <= input_stall_cycles + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d samples outstanding",
                     cycle_count, pending_samples.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] reg_mask(input logic [2:0] addr);
        case (addr)
            CFG_MODE:                                 return 32'h0000_0003;
            CFG_PERIOD, CFG_PULSE_START, CFG_PULSE_WIDTH: return 32'h0000_FFFF;
            CFG_AMPLITUDE:                            return 32'h0000_1FFF;
            default:                                  return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic shadow_reset();
        cfg_shadow[CFG_MODE]        = MODE_LFM;
        cfg_shadow[CFG_PERIOD]      = 4096;
        cfg_shadow[CFG_PULSE_START] = 100;
        cfg_shadow[CFG_PULSE_WIDTH] = 256;
        cfg_shadow[CFG_FREQ_WORD]   = -1398101333;
        cfg_shadow[CFG_CHIRP_STEP]  = 10922667;
        cfg_shadow[CFG_AMPLITUDE]   = 8191;
        cfg_shadow[CFG_CHAN_WORD]   = 341782638;
        sample_pos = '0;
        chan_pos   = '0;
        acc_phase  = '0;
        acc_step   = '0;
        chan_phase = '0;
    endtask

    function automatic logic [15:0] round_sat(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r < -32768)
            r = -32768;
        if (r > 32767)
            r = 32767;
        return r[15:0];
    endfunction

    // Returns {q, i} for the given total phase at the current amplitude.
    function automatic logic [31:0] rotate_phase(input logic [31:0] phase);
        logic [31:0] p;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy, c, s;
        // Shift by an eighth of a turn so the residual angle is centered.
        p    = phase + 32'h2000_0000;
        quad = p[31:30];
        z    = longint'(p[29:0]) - 536870912;
        x    = (longint'(cfg_shadow[CFG_AMPLITUDE][12:0]) * GAIN_Q30 + 8192) >>> 14;
        y    = 0;
        for (int n = 0; n < ROT_STAGES; n++) begin
            dx = y >>> n;
            dy = x >>> n;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turns[n];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turns[n];
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        return {round_sat(s), round_sat(c)};
    endfunction

    function automatic t_tone_sample synth_next(input logic restart);
        t_tone_sample r;
        logic [1:0]   mode;
        logic [15:0]  s, start, width;
        logic [5:0]   ch;
        logic [15:0]  k;
        logic [31:0]  p, fst, cst, half, base, inc;
        logic         in_win, active, last_ch, last_s;
        int           period;

        mode  = cfg_shadow[CFG_MODE][1:0];
        start = cfg_shadow[CFG_PULSE_START][15:0];
        width = cfg_shadow[CFG_PULSE_WIDTH][15:0];
        fst   = cfg_shadow[CFG_FREQ_WORD];
        cst   = cfg_shadow[CFG_CHIRP_STEP];
        if (restart) begin
            sample_pos = '0;
            chan_pos   = '0;
            acc_phase  = '0;
            acc_step   = '0;
            chan_phase = '0;
        end
        s      = sample_pos;
        ch     = chan_pos;
        in_win = (s >= start) && ((s - start) < width);
        k      = in_win ? s - start : 16'd0;
        active = 1'b1;
        p      = '0;
        if (mode == MODE_LFM) begin
            active = in_win;
            p      = (k == 0) ? 32'd0 : acc_phase;
        end else if (mode == MODE_TONE) begin
            p = acc_phase;
        end
        {r.q_val, r.i_val} = active ? rotate_phase(p + chan_phase) : 32'd0;

        period  = (cfg_shadow[CFG_PERIOD][15:0] == 0) ? 1 : int'(cfg_shadow[CFG_PERIOD][15:0]);
        last_ch = int'(ch) + 1 >= NUM_CH;
        last_s  = int'(s) + 1 >= period;
        r.sample = s;
        r.chan   = ch;
        r.eop    = last_ch && last_s;

        if (!last_ch) begin
            chan_pos   = ch + 6'd1;
            chan_phase = chan_phase + cfg_shadow[CFG_CHAN_WORD];
            return r;
        end
        chan_pos   = '0;
        chan_phase = '0;
        if (last_s) begin
            sample_pos = '0;
            acc_phase  = '0;
            acc_step   = '0;
            return r;
        end
        sample_pos = s + 16'd1;
        if (mode == MODE_LFM) begin
            if (in_win) begin
                // The first step carries half a chirp step on top of the start frequency.
                half      = {cst[31], cst[31:1]};
                base      = (k == 0) ? 32'd0 : acc_phase;
                inc       = (k == 0) ? fst + half : acc_step;
                acc_phase = base + inc;
                acc_step  = inc + cst;
            end else begin
                acc_phase = '0;
                acc_step  = '0;
            end
        end else if (mode == MODE_TONE) begin
            acc_phase = acc_phase + fst;
        end else begin
            acc_phase = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic set_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] bus;
        bus = value & reg_mask(addr);
        if ($urandom_range(0, 3) == 0)
            bus = bus | ($urandom & ~reg_mask(addr));
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= bus;
        @(posedge i_clk);
        cfg_shadow[addr] = bus & reg_mask(addr);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Leaves tvalid high after acceptance so back-to-back items need no toggling.
    task automatic send_item(input logic restart);
        int gap;
        gap = tx_gaps_on ? gap_len() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, restart};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        pending_samples.push_back(synth_next(restart));
        items_sent++;
        if (restart)
            restarts_sent++;
    endtask

    task automatic end_burst();
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_samples.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(input logic [2:0] addr);
        bit extreme;
        extreme = $urandom_range(0, 3) == 0;
        case (addr)
            CFG_MODE:
                return $urandom_range(0, 3);
            CFG_PERIOD:
                if (extreme)
                    case ($urandom_range(0, 2))
                        0:       return 0;
                        1:       return 1;
                        default: return 32'hFFFF;
                    endcase
                else
                    return $urandom_range(1, 12);
            CFG_PULSE_START:
                if (extreme)
                    return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF;
                else
                    return $urandom_range(0, 6);
            CFG_PULSE_WIDTH:
                if (extreme)
                    case ($urandom_range(0, 2))
                        0:       return 0;
                        1:       return 1;
                        default: return 32'hFFFF;
                    endcase
                else
                    return $urandom_range(1, 8);
            CFG_AMPLITUDE:
                if (extreme)
                    return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'd8191;
                else
                    return $urandom_range(0, 8191);
            default:
                if (extreme)
                    case ($urandom_range(0, 3))
                        0:       return 32'h0000_0000;
                        1:       return 32'h8000_0000;
                        2:       return 32'h7FFF_FFFF;
                        default: return 32'hFFFF_FFFF;
                    endcase
                else
                    return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH %s at result %0d (cycle %0d): got %0h, expected %0h",
                     what, results_checked, cycle_count, got, want);
        mismatch_count++;
    endtask

    task automatic check_sample();
        t_tone_sample want;
        if (pending_samples.size() == 0) begin
            report_mismatch("unexpected item", o_m_axis_tdata, 0);
            return;
        end
        want = pending_samples.pop_front();
        if (o_m_axis_tdata[15:0] !== want.i_val)
            report_mismatch("i_value", o_m_axis_tdata[15:0], want.i_val);
        if (o_m_axis_tdata[31:16] !== want.q_val)
            report_mismatch("q_value", o_m_axis_tdata[31:16], want.q_val);
        if (o_m_axis_tdata[47:32] !== want.sample)
            report_mismatch("sample_index", o_m_axis_tdata[47:32], want.sample);
        if (o_m_axis_tdata[53:48] !== want.chan)
            report_mismatch("channel_index", o_m_axis_tdata[53:48], want.chan);
        if (o_m_axis_tdata[55:54] !== 2'b00)
            report_mismatch("tdata padding", o_m_axis_tdata[55:54], 0);
        if (o_m_axis_tlast !== want.eop)
            report_mismatch("end_of_period", o_m_axis_tlast, want.eop);
        results_checked++;
    endtask

    // Receiver: checks each accepted item and decides tready for the next cycle.
    initial begin
        int stall_left;
        int held;
        stall_left = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                check_sample();
            if (rx_hold_req) begin
                i_m_axis_tready <= 1'b0;
                held++;
                if (held >= RX_HOLD_LEN) begin
                    rx_hold_req = 1'b0;
                    held = 0;
                end
            end else begin
                if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 5) == 0)
                    stall_left = gap_len();
                if (stall_left > 0) begin
                    i_m_axis_tready <= 1'b0;
                    stall_left--;
                end else begin
                    i_m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: the default chirp window starts far beyond these samples.
    task automatic test_reset_defaults();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        for (int n = 0; n < 4; n++)
            send_item(1'b0);
        end_burst();
        wait_drain();
    endtask

    task automatic test_special_cases();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        // Unused mode code and a zero period: every sample closes a period.
        set_reg(CFG_MODE, MODE_UNUSED);
        set_reg(CFG_PERIOD, 0);
        set_reg(CFG_AMPLITUDE, 8191);
        set_reg(CFG_CHAN_WORD, 32'h8000_0000);
        end_writes();
        send_item(1'b1);
        for (int n = 0; n < 7; n++)
            send_item(1'b0);
        end_burst();
        wait_drain();

        // Tone at the frequency extreme, restarted in the middle of a sample.
        set_reg(CFG_MODE, MODE_TONE);
        set_reg(CFG_PERIOD, 2);
        set_reg(CFG_FREQ_WORD, 32'h7FFF_FFFF);
        set_reg(CFG_CHAN_WORD, 32'hFFFF_FFFF);
        end_writes();
        for (int n = 0; n < 5; n++)
            send_item(1'b0);
        send_item(1'b1);
        for (int n = 0; n < 3; n++)
            send_item(1'b0);
        end_burst();
        wait_drain();

        // A zero-width chirp window never opens.
        set_reg(CFG_MODE, MODE_LFM);
        set_reg(CFG_PULSE_START, 0);
        set_reg(CFG_PULSE_WIDTH, 0);
        set_reg(CFG_CHIRP_STEP, 32'h8000_0000);
        set_reg(CFG_AMPLITUDE, 0);
        end_writes();
        send_item(1'b1);
        for (int n = 0; n < 3; n++)
            send_item(1'b0);
        end_burst();
        wait_drain();
    endtask

    // Random settings, mostly short periods and windows so chirps run deep.
    // Restarts are rare so the accumulators carry across settings.
    task automatic test_random_settings(input int n_items);
        int  done;
        int  burst;
        bit  restart;
        done = 0;
        while (done < n_items) begin
            for (int a = 0; a < 8; a++)
                if (done == 0 || $urandom_range(0, 1) == 0)
                    set_reg(a[2:0], pick_value(a[2:0]));
            end_writes();
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            burst = $urandom_range(8, 96);
            if (burst > n_items - done)
                burst = n_items - done;
            for (int n = 0; n < burst; n++) begin
                if (n == 0)
                    restart = $urandom_range(0, 2) == 0;
                else
                    restart = $urandom_range(0, 29) == 0;
                send_item(restart);
            end
            end_burst();
            wait_drain();
            done += burst;
        end
    endtask

    // The receiver stops for a long stretch while items keep coming.
    task automatic test_receiver_hold();
        set_reg(CFG_MODE, MODE_TONE);
        set_reg(CFG_AMPLITUDE, $urandom_range(1, 8191));
        set_reg(CFG_FREQ_WORD, $urandom);
        end_writes();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        rx_hold_req  = 1'b1;
        for (int n = 0; n < 48; n++)
            send_item(1'b0);
        end_burst();
        wait_drain();
    endtask

    initial begin
        shadow_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_special_cases();
        test_random_settings(170);
        test_receiver_hold();
        test_random_settings(170);

        wait_drain();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (pending_samples.size() != 0)
            report_mismatch("missing items", pending_samples.size(), 0);

        $display("Sent %0d items (%0d with restart) over %0d register settings.",
                 items_sent, restarts_sent, settings_used);
        $display("Checked %0d samples; input stalled for %0d cycles under back-pressure.",
                 results_checked, input_stall_cycles);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/mctg_pkg.sv
rtl/mctg_cell.sv
rtl/mctg_post.sv
rtl/multichannel_chirp_tone_generator.sv
test/multichannel_chirp_tone_generator_tb.sv
